### rtl/gbfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbfd_pkg
// Shared types and constants of the gyroscope burst frame decoder.
// ----------------------------------------------------------------------------
package gbfd_pkg;

  // Status codes carried with each decoded frame.
  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_BUS_FAULT   = 2'd1;
  localparam logic [1:0] STAT_ID_MISMATCH = 2'd2;

  localparam logic [7:0] ID_RESET = 8'h0F;

  // Byte positions inside one burst run from 0 to LAST_POS.
  localparam int unsigned POS_W    = 4;
  localparam logic [POS_W-1:0] LAST_POS = 4'd8;

  // Bytes 1..7 of a burst are kept; byte 8 is used as it arrives.
  localparam int unsigned STORE_DEPTH = 7;

  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned MDPS_W   = 22;
  localparam int unsigned PROD_W   = 30;

  // Milli-degrees per second = count * 15625 / 256.
  localparam logic signed [PROD_W-1:0] SCALE_NUM  = 30'sd15625;
  localparam int unsigned              SCALE_SHIFT = 8;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [COUNT_W-1:0] x;
    logic signed [COUNT_W-1:0] y;
    logic signed [COUNT_W-1:0] z;
  } frame_t;

endpackage
`default_nettype wire

### rtl/gbfd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbfd_front
// Byte intake: tracks the position within a burst, collects the frame bytes,
// and on the last byte classifies the frame and pushes it downstream.
// ----------------------------------------------------------------------------
module gbfd_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        expected_id_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic              frame_start_i,
  input  wire logic              bus_fault_i,
  output logic                   push_valid_o,
  input  wire logic              push_ready_i,
  output gbfd_pkg::frame_t       push_frame_o
);
  import gbfd_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d, pos_eff;
  logic             fault_q, fault_d, fault_now;
  logic             accept, last;
  logic [7:0]       store_q [STORE_DEPTH];

  // A full queue holds off the whole byte stream; it only fills if the
  // receiver of results stalls for several frames.
  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    if (frame_start_i || (pos_q > LAST_POS)) begin
      pos_eff = '0;
    end else begin
      pos_eff = pos_q;
    end
  end

  assign last      = (pos_eff == LAST_POS);
  assign fault_now = ((pos_eff == '0) ? 1'b0 : fault_q) | bus_fault_i;

  always_comb begin
    pos_d   = pos_q;
    fault_d = fault_q;
    if (accept) begin
      pos_d   = last ? '0 : pos_eff + 1'b1;
      fault_d = last ? 1'b0 : fault_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      fault_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      fault_q <= fault_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (accept && (pos_eff == POS_W'(i + 1))) begin
        store_q[i] <= rx_byte_i;
      end
    end
  end

  // A bus fault outranks an identifier mismatch.
  always_comb begin
    priority if (fault_now) begin
      push_frame_o.status = STAT_BUS_FAULT;
    end else if (store_q[0] != expected_id_i) begin
      push_frame_o.status = STAT_ID_MISMATCH;
    end else begin
      push_frame_o.status = STAT_OK;
    end
    push_frame_o.x = {store_q[3], store_q[2]};
    push_frame_o.y = {store_q[5], store_q[4]};
    push_frame_o.z = {rx_byte_i, store_q[6]};
  end

  assign push_valid_o = accept & last;

endmodule
`default_nettype wire

### rtl/gbfd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbfd_queue
// Two-entry frame queue between the byte intake and the result stage.
// ----------------------------------------------------------------------------
module gbfd_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_valid_i,
  output logic             push_ready_o,
  input  wire gbfd_pkg::frame_t push_frame_i,
  output logic             pop_valid_o,
  input  wire logic        pop_ready_i,
  output gbfd_pkg::frame_t pop_frame_o
);
  import gbfd_pkg::*;

  frame_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;
  assign pop_frame_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_frame_i;
    end
  end

endmodule
`default_nettype wire

### rtl/gbfd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbfd_back
// Result stage: keeps the last good sample, scales the counts to
// milli-degrees per second and holds the result until it is taken.
// ----------------------------------------------------------------------------
module gbfd_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                pop_valid_i,
  output logic                     pop_ready_o,
  input  wire gbfd_pkg::frame_t    pop_frame_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic signed [15:0]       x_count_o,
  output logic signed [15:0]       y_count_o,
  output logic signed [15:0]       z_count_o,
  output logic signed [21:0]       x_millideg_o,
  output logic signed [21:0]       y_millideg_o,
  output logic signed [21:0]       z_millideg_o,
  output logic [1:0]               frame_status_o
);
  import gbfd_pkg::*;

  logic                      pop, s1_adv;
  logic                      s1_valid_q, out_valid_q;
  logic [1:0]                s1_stat_q, out_stat_q;
  logic signed [COUNT_W-1:0] held_q   [NUM_AXES];
  logic signed [COUNT_W-1:0] new_cnt  [NUM_AXES];
  logic signed [COUNT_W-1:0] sel_cnt  [NUM_AXES];
  logic signed [COUNT_W-1:0] s1_cnt_q [NUM_AXES];
  logic signed [COUNT_W-1:0] out_cnt_q[NUM_AXES];
  logic signed [PROD_W-1:0]  s1_prod_q[NUM_AXES];
  logic signed [PROD_W-1:0]  prod     [NUM_AXES];
  logic signed [PROD_W-1:0]  biased   [NUM_AXES];
  logic signed [MDPS_W-1:0]  out_mdps_q[NUM_AXES];
  logic                      good;

  assign s1_adv      = ~out_valid_q | out_ready_i;
  assign pop_ready_o = ~s1_valid_q | s1_adv;
  assign pop         = pop_valid_i & pop_ready_o;
  assign good        = (pop_frame_i.status == STAT_OK);

  assign new_cnt[0] = pop_frame_i.x;
  assign new_cnt[1] = pop_frame_i.y;
  assign new_cnt[2] = pop_frame_i.z;

  // Faulty frames repeat the last good sample.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      sel_cnt[a] = good ? new_cnt[a] : held_q[a];
      prod[a]    = PROD_W'(sel_cnt[a]) * SCALE_NUM;
      // Bias negative products so the arithmetic shift truncates toward zero.
      biased[a]  = s1_prod_q[a] +
                   (s1_prod_q[a][PROD_W-1] ? PROD_W'((1 << SCALE_SHIFT) - 1) : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        held_q[a] <= '0;
      end
    end else begin
      if (pop_ready_o) begin
        s1_valid_q <= pop_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (pop && good) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          held_q[a] <= new_cnt[a];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_stat_q <= pop_frame_i.status;
      for (int a = 0; a < NUM_AXES; a++) begin
        s1_cnt_q[a]  <= sel_cnt[a];
        s1_prod_q[a] <= prod[a];
      end
    end
    if (s1_valid_q && s1_adv) begin
      out_stat_q <= s1_stat_q;
      for (int a = 0; a < NUM_AXES; a++) begin
        out_cnt_q[a]  <= s1_cnt_q[a];
        out_mdps_q[a] <= MDPS_W'(biased[a] >>> SCALE_SHIFT);
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign x_count_o      = out_cnt_q[0];
  assign y_count_o      = out_cnt_q[1];
  assign z_count_o      = out_cnt_q[2];
  assign x_millideg_o   = out_mdps_q[0];
  assign y_millideg_o   = out_mdps_q[1];
  assign z_millideg_o   = out_mdps_q[2];
  assign frame_status_o = out_stat_q;

endmodule
`default_nettype wire

### rtl/gyro_burst_frame_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gyro_burst_frame_decoder
// Decodes nine-byte gyroscope bursts into rate counts and milli-degrees/s.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one received byte per
//   transfer with its frame_start and bus_fault flags. A byte may be
//   transferred every cycle while in_ready_o is high. Byte 0 is discarded,
//   byte 1 is checked against the expected_id register, bytes 3..8 hold
//   X, Y, Z little-endian. After the ninth byte one result appears on the
//   output channel (out_valid_o / out_ready_i); the frame passes through
//   the frame queue and the multiply stage, then through the output
//   register. Results: raw counts, counts * 15625 / 256 truncated toward
//   zero, and a status (ok, bus fault, identifier mismatch). On an error the
//   last good sample is repeated.
//   A stalled receiver holds the result in the output register; frames back
//   up into a two-entry queue, and only when that is full is in_ready_o low.
//   Reset clears the byte position, the held sample (zero) and sets the
//   expected identifier to 0x0F. cfg_we_i writes cfg_wdata_i into it; write
//   only while no frame is in progress.
// ----------------------------------------------------------------------------
module gyro_burst_frame_decoder (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [7:0]        cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic              frame_start_i,
  input  wire logic              bus_fault_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic signed [15:0]     x_count_o,
  output logic signed [15:0]     y_count_o,
  output logic signed [15:0]     z_count_o,
  output logic signed [21:0]     x_millideg_o,
  output logic signed [21:0]     y_millideg_o,
  output logic signed [21:0]     z_millideg_o,
  output logic [1:0]             frame_status_o
);
  import gbfd_pkg::*;

  logic [7:0] expected_id_q;
  logic       push_valid, push_ready, pop_valid, pop_ready;
  frame_t     push_frame, pop_frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_id_q <= ID_RESET;
    end else if (cfg_we_i) begin
      expected_id_q <= cfg_wdata_i;
    end
  end

  gbfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .expected_id_i (expected_id_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .bus_fault_i   (bus_fault_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_frame_o  (push_frame)
  );

  gbfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_frame_i (push_frame),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_frame_o  (pop_frame)
  );

  gbfd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_frame_i    (pop_frame),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .x_count_o      (x_count_o),
    .y_count_o      (y_count_o),
    .z_count_o      (z_count_o),
    .x_millideg_o   (x_millideg_o),
    .y_millideg_o   (y_millideg_o),
    .z_millideg_o   (z_millideg_o),
    .frame_status_o (frame_status_o)
  );

endmodule
`default_nettype wire
